### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every edge outside reset.
`define ALFG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Condition in one cycle implies a consequence in the next.
`define ALFG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### sv/alfg_pkg.sv
package alfg_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    // cell positions and pointers, sized for the deepest table supported
    localparam int IDX_W  = 11;
    localparam int DATA_W = 31;
    localparam int LEN_W  = 7;
    localparam int LAG_W  = 6;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 31;

    localparam logic [CFG_AW-1:0] CFG_TABLE_LENGTH = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MODULUS      = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SHORT_LAG    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_LONG_LAG     = 3'd3;

    localparam logic KIND_DRAW     = 1'b0;
    localparam logic KIND_LOAD     = 1'b1;
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    localparam logic [LEN_W-1:0]  LEN_RST       = 7'd64;
    localparam logic [DATA_W-1:0] MOD_RST       = 31'h7FFF_FFFF;
    localparam logic [LAG_W-1:0]  SHORT_LAG_RST = 6'd24;
    localparam logic [LAG_W-1:0]  LONG_LAG_RST  = 6'd55;

    localparam int MIN_LEN = 2;
    localparam int MIN_MOD = 2;

    typedef struct packed {
        logic [LEN_W-1:0]  table_length;
        logic [DATA_W-1:0] modulus;
        logic [LAG_W-1:0]  short_lag;
        logic [LAG_W-1:0]  long_lag;
    } t_cfg;

    // broadcast to every cell
    typedef struct packed {
        logic              draw;
        logic              load;
        logic [IDX_W-1:0]  len;
        logic [IDX_W-1:0]  load_idx;
        logic [IDX_W-1:0]  short_lag;
        logic [IDX_W-1:0]  long_lag;
        logic [DATA_W-1:0] wr_data;
        logic              s_none;
        logic              l_none;
    } t_cell_ctrl;

    typedef struct packed {
        logic s_hit;
        logic l_hit;
        logic s_sel;
        logic l_sel;
    } t_cell_flags;

endpackage

### sv/alfg_if.sv
interface alfg_req_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [alfg_pkg::LEN_W-1:0]  index;
    logic [alfg_pkg::DATA_W-1:0] value;

    modport source (output valid, kind, index, value, input ready);
    modport sink   (input valid, kind, index, value, output ready);
endinterface

interface alfg_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [alfg_pkg::DATA_W-1:0] number;
    logic                       status;

    modport source (output valid, number, status, input ready);
    modport sink   (input valid, number, status, output ready);
endinterface

interface alfg_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [alfg_pkg::CFG_AW-1:0] addr;
    logic [alfg_pkg::CFG_DW-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

### sv/alfg_cfg.sv
module alfg_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    alfg_cfg_if.sink        i_cfg,
    output alfg_pkg::t_cfg  o_cfg
);

    alfg_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_length <= alfg_pkg::LEN_RST;
            r_cfg.modulus      <= alfg_pkg::MOD_RST;
            r_cfg.short_lag    <= alfg_pkg::SHORT_LAG_RST;
            r_cfg.long_lag     <= alfg_pkg::LONG_LAG_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                alfg_pkg::CFG_TABLE_LENGTH: begin
                    r_cfg.table_length <= i_cfg.data[alfg_pkg::LEN_W-1:0];
                end
                alfg_pkg::CFG_MODULUS: begin
                    r_cfg.modulus <= i_cfg.data[alfg_pkg::DATA_W-1:0];
                end
                alfg_pkg::CFG_SHORT_LAG: begin
                    r_cfg.short_lag <= i_cfg.data[alfg_pkg::LAG_W-1:0];
                end
                alfg_pkg::CFG_LONG_LAG: begin
                    r_cfg.long_lag <= i_cfg.data[alfg_pkg::LAG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### sv/alfg_cell.sv
// One table entry plus the two pointer tokens. Tokens step to the lower
// neighbour on every draw; cell 1 wraps to len, long only if short did not.
module alfg_cell #(
    parameter int CELL_IDX = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  alfg_pkg::t_cell_ctrl         i_ctrl,
    input  logic                         i_s_next,
    input  logic                         i_l_next,
    input  logic                         i_s_first,
    input  logic                         i_l_first,
    output alfg_pkg::t_cell_flags        o_flags,
    output logic [alfg_pkg::DATA_W-1:0]  o_s_data,
    output logic [alfg_pkg::DATA_W-1:0]  o_l_data
);

    localparam logic [alfg_pkg::IDX_W-1:0] POS = alfg_pkg::IDX_W'(CELL_IDX);

    logic                        r_s_tok;
    logic                        r_l_tok;
    logic [alfg_pkg::DATA_W-1:0] r_entry;

    logic w_at_len;
    logic w_in_len;
    logic w_s_sel;
    logic w_l_sel;

    assign w_at_len = (POS == i_ctrl.len);
    assign w_in_len = (POS <= i_ctrl.len);

    // a pointer with no token inside the length falls back to the cell at len
    assign w_s_sel = (r_s_tok & w_in_len) | (w_at_len & i_ctrl.s_none);
    assign w_l_sel = (r_l_tok & w_in_len) | (w_at_len & i_ctrl.l_none);

    assign o_flags.s_hit = r_s_tok & w_in_len;
    assign o_flags.l_hit = r_l_tok & w_in_len;
    assign o_flags.s_sel = w_s_sel;
    assign o_flags.l_sel = w_l_sel;

    assign o_s_data = r_entry & {alfg_pkg::DATA_W{w_s_sel}};
    assign o_l_data = r_entry & {alfg_pkg::DATA_W{w_l_sel}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_tok <= (POS == alfg_pkg::IDX_W'(alfg_pkg::SHORT_LAG_RST));
            r_l_tok <= (POS == alfg_pkg::IDX_W'(alfg_pkg::LONG_LAG_RST));
            r_entry <= '0;
        end else if (i_ctrl.load) begin
            r_s_tok <= (POS == i_ctrl.short_lag);
            r_l_tok <= (POS == i_ctrl.long_lag);
            if (POS == i_ctrl.load_idx) begin
                r_entry <= i_ctrl.wr_data;
            end
        end else if (i_ctrl.draw) begin
            r_s_tok <= i_s_next | (w_at_len & i_s_first);
            // long pointer wraps only when the short one did not
            r_l_tok <= i_l_next | (w_at_len & i_l_first & ~i_s_first);
            if (w_l_sel) begin
                r_entry <= i_ctrl.wr_data;
            end
        end
    end

endmodule

### sv/additive_lagged_fibonacci_rng.sv
// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    kind, index, value
// o_rsp     out  valid/ready    number, status
// i_cfg     in   valid/ready    addr, data (ready always high)
//
// One item per clock unless stalled; each result is registered as it is taken.
// The step is one pass through the cell row: token select, add, one
// conditional subtract of the modulus, write back into the long-pointer cell.
// Synchronous reset clears every table entry directly, no sweep.
// i_req.ready drops only while a result is held and o_rsp.ready is low.
module additive_lagged_fibonacci_rng #(
    parameter int TABLE_DEPTH = alfg_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alfg_req_if.sink    i_req,
    alfg_rsp_if.source  o_rsp,
    alfg_cfg_if.sink    i_cfg
);

    `include "assert_macros.svh"

    localparam int IW = alfg_pkg::IDX_W;
    localparam int DW = alfg_pkg::DATA_W;

    alfg_pkg::t_cfg        w_cfg;
    alfg_pkg::t_cell_ctrl  w_ctrl;
    alfg_pkg::t_cell_flags w_flags [TABLE_DEPTH];
    logic [DW-1:0]         w_s_data [TABLE_DEPTH];
    logic [DW-1:0]         w_l_data [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] w_s_hit;
    logic [TABLE_DEPTH-1:0] w_l_hit;
    logic [TABLE_DEPTH-1:0] w_s_sel;
    logic [TABLE_DEPTH-1:0] w_l_sel;

    logic [IW-1:0] w_len_raw;
    logic [IW-1:0] w_len;
    logic [DW-1:0] w_mod;
    logic [DW-1:0] w_opnd_a;
    logic [DW-1:0] w_opnd_b;
    logic [DW:0]   w_sum_raw;
    logic [DW:0]   w_sum_red;
    logic [DW-1:0] w_result;

    logic w_accept;
    logic w_draw;
    logic w_reject;
    logic w_load;

    logic          r_out_valid;
    logic [DW-1:0] r_number;
    logic          r_status;

    alfg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    assign w_len_raw = IW'(w_cfg.table_length);
    always_comb begin
        if (w_len_raw < IW'(alfg_pkg::MIN_LEN)) begin
            w_len = IW'(alfg_pkg::MIN_LEN);
        end else if (w_len_raw > IW'(TABLE_DEPTH)) begin
            w_len = IW'(TABLE_DEPTH);
        end else begin
            w_len = w_len_raw;
        end
    end

    assign w_mod = (w_cfg.modulus < DW'(alfg_pkg::MIN_MOD)) ? DW'(alfg_pkg::MIN_MOD)
                                                            : w_cfg.modulus;

    assign i_req.ready = ~r_out_valid | o_rsp.ready;
    assign w_accept    = i_req.valid & i_req.ready;
    assign w_draw      = w_accept & (i_req.kind == alfg_pkg::KIND_DRAW);
    assign w_reject    = w_accept & (i_req.kind == alfg_pkg::KIND_LOAD) &
                         (i_req.value >= w_mod);
    assign w_load      = w_accept & (i_req.kind == alfg_pkg::KIND_LOAD) & ~w_reject;

    always_comb begin
        w_opnd_a = '0;
        w_opnd_b = '0;
        for (int c = 0; c < TABLE_DEPTH; c++) begin
            w_s_hit[c] = w_flags[c].s_hit;
            w_l_hit[c] = w_flags[c].l_hit;
            w_s_sel[c] = w_flags[c].s_sel;
            w_l_sel[c] = w_flags[c].l_sel;
            w_opnd_a   = w_opnd_a | w_s_data[c];
            w_opnd_b   = w_opnd_b | w_l_data[c];
        end
    end

    // operands may exceed a lowered modulus; still only one subtract
    assign w_sum_raw = {1'b0, w_opnd_a} + {1'b0, w_opnd_b};
    assign w_sum_red = (w_sum_raw >= {1'b0, w_mod}) ? (w_sum_raw - {1'b0, w_mod})
                                                    : w_sum_raw;
    assign w_result  = w_sum_red[DW-1:0];

    assign w_ctrl.draw      = w_draw;
    assign w_ctrl.load      = w_load;
    assign w_ctrl.len       = w_len;
    assign w_ctrl.load_idx  = IW'(i_req.index);
    assign w_ctrl.short_lag = IW'(w_cfg.short_lag);
    assign w_ctrl.long_lag  = IW'(w_cfg.long_lag);
    assign w_ctrl.wr_data   = w_draw ? w_result : i_req.value;
    assign w_ctrl.s_none    = ~|w_s_hit;
    assign w_ctrl.l_none    = ~|w_l_hit;

    for (genvar c = 0; c < TABLE_DEPTH; c++) begin : g_cell
        logic w_s_next;
        logic w_l_next;
        if (c == TABLE_DEPTH - 1) begin : g_last
            assign w_s_next = 1'b0;
            assign w_l_next = 1'b0;
        end else begin : g_mid
            assign w_s_next = w_s_sel[c+1];
            assign w_l_next = w_l_sel[c+1];
        end

        alfg_cell #(
            .CELL_IDX (c + 1)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_s_next  (w_s_next),
            .i_l_next  (w_l_next),
            .i_s_first (w_s_sel[0]),
            .i_l_first (w_l_sel[0]),
            .o_flags   (w_flags[c]),
            .o_s_data  (w_s_data[c]),
            .o_l_data  (w_l_data[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_number <= w_draw ? w_result : '0;
            r_status <= w_reject ? alfg_pkg::STATUS_REJECT : alfg_pkg::STATUS_OK;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.number = r_number;
    assign o_rsp.status = r_status;

    // every draw reads exactly one cell for each operand
    `ALFG_ASSERT(a_short_sel_onehot, i_clk, i_rst_n, $onehot(w_s_sel))
    `ALFG_ASSERT(a_long_sel_onehot, i_clk, i_rst_n, $onehot(w_l_sel))
    `ALFG_ASSERT(a_short_tok_single, i_clk, i_rst_n, $onehot0(w_s_hit))
    `ALFG_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_accept, o_rsp.valid)
    `ALFG_ASSERT(a_reject_zero, i_clk, i_rst_n, (o_rsp.valid && o_rsp.status) |-> (o_rsp.number == '0))

endmodule
